@@ hw/rtl/qdc_ebp_pkg.sv @@
// ----------------------------------------------------------------------------
// qdc_ebp_pkg
// Types and constants shared by the event-buffer readout parser.
// ----------------------------------------------------------------------------
package qdc_ebp_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned ValueWidth = 12;
  localparam int unsigned CountWidth = 6;
  localparam int unsigned IndexWidth = 5;
  localparam int unsigned OutDataWidth = 16;

  localparam logic [2:0] TypeHeader = 3'h2;
  localparam logic [2:0] TypeData   = 3'h0;
  localparam logic [2:0] TypeEob    = 3'h4;

  localparam logic CfgChannelSelect = 1'b0;
  localparam logic CfgChannelLayout = 1'b1;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhData = 2'd1,
    PhEob  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoHead  = 2'd1,
    StBadData = 2'd2,
    StNoEnd   = 2'd3
  } status_e;

  typedef struct packed {
    logic                  emit;
    logic [ValueWidth-1:0] value;
    status_e               status;
  } result_t;

endpackage

@@ hw/rtl/qdc_event_block_parser.sv @@
// ----------------------------------------------------------------------------
// qdc_event_block_parser
// Parses header / data / end-of-block readout words and reports the selected
// channel's conversion value once per event, or an error status.
//
//   channel   dir  width  contents
//   s_axis    in   32     readout word
//   m_axis    out  16+2   tdata: conversion value; tuser: parse status
//   cfg       in   1+5    register index, write data (no read-back)
//
// One item a cycle while the result register is free: a word sits in the
// input register, and one pass of the parse logic updates state and loads
// the result register; a result passes through those two registers in turn.
// Reset clears parse state, configuration and both valid flags.
// A stalled result holds the input register; the source then sees tready low.
// ----------------------------------------------------------------------------
module qdc_event_block_parser #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] readout_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [11:0] conversion_value, [15:12] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] parse_status
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  logic                 in_valid;
  logic [31:0]          in_word;
  logic                 out_free;
  logic                 step;
  qdc_ebp_pkg::result_t result;

  assign step = in_valid && out_free;

  qdc_ebp_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .step_i          (step),
    .valid_o         (in_valid),
    .word_o          (in_word)
  );

  qdc_ebp_core #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .word_i      (in_word),
    .step_i      (step),
    .result_o    (result)
  );

  qdc_ebp_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && result.emit),
    .result_i        (result),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && result.emit |=> m_axis_tvalid_o)
    else $error("result item not presented after parse step");

  a_error_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != qdc_ebp_pkg::StOk) |-> m_axis_tdata_o == '0)
    else $error("error status carries a non-zero value");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !step |=> in_valid && $stable(in_word))
    else $error("pending readout word lost");

endmodule

@@ hw/rtl/qdc_ebp_in_reg.sv @@
// ----------------------------------------------------------------------------
// qdc_ebp_in_reg
// Input register: holds one readout word until the parser steps on it.
// ----------------------------------------------------------------------------
module qdc_ebp_in_reg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [qdc_ebp_pkg::WordWidth-1:0] s_axis_tdata_i,
  input  logic                             step_i,
  output logic                             valid_o,
  output logic [qdc_ebp_pkg::WordWidth-1:0] word_o
);

  logic                             valid_q, valid_d;
  logic [qdc_ebp_pkg::WordWidth-1:0] word_q;
  logic                             accept;

  assign s_axis_tready_o = !valid_q || step_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= s_axis_tdata_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ hw/rtl/qdc_ebp_core.sv @@
// ----------------------------------------------------------------------------
// qdc_ebp_core
// Parse state machine, configuration registers and channel capture.
// ----------------------------------------------------------------------------
module qdc_ebp_core #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [qdc_ebp_pkg::IndexWidth-1:0] cfg_data_i,
  input  logic [qdc_ebp_pkg::WordWidth-1:0]  word_i,
  input  logic                              step_i,
  output qdc_ebp_pkg::result_t              result_o
);

  localparam logic [qdc_ebp_pkg::IndexWidth:0] MaxCh =
    (qdc_ebp_pkg::IndexWidth+1)'(MAX_CHANNELS);

  qdc_ebp_pkg::phase_e                 phase_q, phase_d;
  logic [qdc_ebp_pkg::CountWidth-1:0]  count_q, count_d;
  logic [qdc_ebp_pkg::ValueWidth-1:0]  capture_q, capture_d;
  logic [qdc_ebp_pkg::IndexWidth-1:0]  select_q;
  logic                                layout_q;

  logic [2:0]                          word_type;
  logic [qdc_ebp_pkg::IndexWidth-1:0]  chan_idx;
  logic                                chan_hit;
  logic [qdc_ebp_pkg::CountWidth-1:0]  count_dec;
  logic [qdc_ebp_pkg::CountWidth-1:0]  header_count;

  assign word_type    = word_i[26:24];
  assign chan_idx     = layout_q ? {1'b0, word_i[20:17]} : word_i[20:16];
  assign chan_hit     = ({1'b0, chan_idx} < MaxCh) && (chan_idx == select_q);
  assign count_dec    = count_q - 1'b1;
  assign header_count = word_i[13:8];

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    capture_d = capture_q;
    result_o = '0;
    unique case (phase_q)
      qdc_ebp_pkg::PhData: begin
        if (word_type != qdc_ebp_pkg::TypeData) begin
          phase_d         = qdc_ebp_pkg::PhIdle;
          count_d         = '0;
          result_o.emit   = 1'b1;
          result_o.status = qdc_ebp_pkg::StBadData;
        end else begin
          if (chan_hit) begin
            capture_d = word_i[qdc_ebp_pkg::ValueWidth-1:0];
          end
          count_d = count_dec;
          if (count_dec == '0) begin
            phase_d = qdc_ebp_pkg::PhEob;
          end
        end
      end
      qdc_ebp_pkg::PhEob: begin
        phase_d       = qdc_ebp_pkg::PhIdle;
        count_d       = '0;
        result_o.emit = 1'b1;
        if (word_type == qdc_ebp_pkg::TypeEob) begin
          result_o.value  = capture_q;
          result_o.status = qdc_ebp_pkg::StOk;
        end else begin
          result_o.status = qdc_ebp_pkg::StNoEnd;
        end
      end
      default: begin
        phase_d = qdc_ebp_pkg::PhIdle;
        if (word_type != qdc_ebp_pkg::TypeHeader) begin
          result_o.emit   = 1'b1;
          result_o.status = qdc_ebp_pkg::StNoHead;
        end else begin
          count_d   = header_count;
          capture_d = '0;
          phase_d   = (header_count == '0) ? qdc_ebp_pkg::PhEob : qdc_ebp_pkg::PhData;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= qdc_ebp_pkg::PhIdle;
      count_q   <= '0;
      capture_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      capture_q <= capture_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_q <= '0;
      layout_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == qdc_ebp_pkg::CfgChannelSelect) begin
        select_q <= cfg_data_i;
      end else if (cfg_index_i == qdc_ebp_pkg::CfgChannelLayout) begin
        layout_q <= cfg_data_i[0];
      end
    end
  end

endmodule

@@ hw/rtl/qdc_ebp_out_reg.sv @@
// ----------------------------------------------------------------------------
// qdc_ebp_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module qdc_ebp_out_reg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  qdc_ebp_pkg::result_t                  result_i,
  output logic                                  free_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [qdc_ebp_pkg::OutDataWidth-1:0]  m_axis_tdata_o,
  output logic [1:0]                            m_axis_tuser_o
);

  logic                               valid_q, valid_d;
  logic [qdc_ebp_pkg::ValueWidth-1:0] value_q;
  qdc_ebp_pkg::status_e               status_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q  <= result_i.value;
      status_q <= result_i.status;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(qdc_ebp_pkg::OutDataWidth - qdc_ebp_pkg::ValueWidth){1'b0}},
                            value_q};
  assign m_axis_tuser_o  = status_q;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the event-buffer readout parser. A directed table
// covers reset state, field extremes and every parse status. Random events
// follow, mostly well formed, some cut short or noisy. They run under several
// channel settings and idle patterns, and once with the output held off long
// enough to stall the input. Each result is checked against the table's
// expected result where a row gives one, else against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import qdc_ebp_pkg::*;

  localparam int unsigned ChanLimit  = 32;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DirRows    = 29;
  localparam int unsigned PhaseItems = 240;

  typedef enum logic {RowWord, RowCfg} row_kind_e;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    status_e               status;
  } readout_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [WordWidth-1:0]  word;
    bit                    typed;
    bit                    t_emit;
    logic [ValueWidth-1:0] t_value;
    status_e               t_status;
    logic                  cfg_index;
    logic [IndexWidth-1:0] cfg_data;
  } dir_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = 1'b0;
  logic [4:0]  cfg_data_i      = '0;

  qdc_event_block_parser #(
    .MAX_CHANNELS(ChanLimit)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  phase_e                model_phase     = PhIdle;
  logic [CountWidth-1:0] model_remaining = '0;
  logic [ValueWidth-1:0] model_captured  = '0;
  logic [IndexWidth-1:0] model_select    = '0;
  logic                  model_layout    = 1'b0;

  readout_t    awaited_reports[$];
  readout_t    head;
  int unsigned fail_count   = 0;
  int unsigned sent_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_off     = 1'b0;
  event        hold_off_go;

  dir_row_t directed_rows [DirRows] = '{
    '{RowWord, 32'h0000_0ABC, 1'b1, 1'b1, 12'h000, StNoHead,  1'b0, 5'd0},
    '{RowWord, 32'hFFFF_FFFF, 1'b1, 1'b1, 12'h000, StNoHead,  1'b0, 5'd0},
    '{RowWord, 32'h0200_0200, 1'b1, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0000_0FFF, 1'b1, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0001_0123, 1'b1, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0400_0000, 1'b1, 1'b1, 12'hFFF, StOk,      1'b0, 5'd0},
    '{RowWord, 32'hFAFF_C0FF, 1'b1, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'hFCFF_FFFF, 1'b1, 1'b1, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0200_0100, 1'b1, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0400_0000, 1'b1, 1'b1, 12'h000, StBadData, 1'b0, 5'd0},
    '{RowWord, 32'h0200_0100, 1'b1, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0000_0001, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0200_0000, 1'b1, 1'b1, 12'h000, StNoEnd,   1'b0, 5'd0},
    '{RowCfg,  32'h0000_0000, 1'b0, 1'b0, 12'h000, StOk,      CfgChannelSelect, 5'd31},
    '{RowWord, 32'h0200_0300, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'hF8FF_FAAA, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h001F_0555, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h001E_0777, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0400_0000, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowCfg,  32'h0000_0000, 1'b0, 1'b0, 12'h000, StOk,      CfgChannelLayout, 5'd1},
    '{RowCfg,  32'h0000_0000, 1'b0, 1'b0, 12'h000, StOk,      CfgChannelSelect, 5'd7},
    '{RowWord, 32'h0200_0200, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h000E_0321, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h000F_0654, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0400_0000, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowCfg,  32'h0000_0000, 1'b0, 1'b0, 12'h000, StOk,      CfgChannelSelect, 5'd31},
    '{RowWord, 32'h0200_0100, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h001E_0FFF, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0},
    '{RowWord, 32'h0400_0000, 1'b0, 1'b0, 12'h000, StOk,      1'b0, 5'd0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void parse_readout_word(input logic [WordWidth-1:0] word,
                                             output bit emits, output readout_t res);
    logic [2:0]            kind;
    logic [IndexWidth-1:0] chan;
    kind       = word[26:24];
    emits      = 1'b1;
    res.value  = '0;
    res.status = StOk;
    case (model_phase)
      PhData: begin
        if (kind != TypeData) begin
          model_phase     = PhIdle;
          model_remaining = '0;
          res.status      = StBadData;
        end else begin
          chan = model_layout ? {1'b0, word[20:17]} : word[20:16];
          if (chan < ChanLimit && chan == model_select) model_captured = word[11:0];
          model_remaining = model_remaining - 1'b1;
          if (model_remaining == 0) model_phase = PhEob;
          emits = 1'b0;
        end
      end
      PhEob: begin
        model_phase     = PhIdle;
        model_remaining = '0;
        if (kind == TypeEob) res.value = model_captured;
        else res.status = StNoEnd;
      end
      default: begin
        model_phase = PhIdle;
        if (kind != TypeHeader) begin
          res.status = StNoHead;
        end else begin
          model_remaining = word[13:8];
          model_captured  = '0;
          model_phase     = (model_remaining == 0) ? PhEob : PhData;
          emits           = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic logic [WordWidth-1:0] word_of_type(input logic [2:0] kind);
    logic [WordWidth-1:0] w;
    w        = $urandom;
    w[26:24] = kind;
    return w;
  endfunction

  function automatic logic [WordWidth-1:0] word_not_of_type(input logic [2:0] kind);
    logic [2:0] t;
    do t = 3'($urandom_range(7)); while (t == kind);
    return word_of_type(t);
  endfunction

  task automatic send_word(input logic [WordWidth-1:0] word, input bit typed = 1'b0,
                           input bit t_emit = 1'b0, input logic [ValueWidth-1:0] t_value = '0,
                           input status_e t_status = StOk);
    bit       emits;
    readout_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_readout_word(word, emits, res);
    if (typed) begin
      emits      = t_emit;
      res.value  = t_value;
      res.status = t_status;
    end
    if (emits) awaited_reports.push_back(res);
    sent_count++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [IndexWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgChannelSelect) model_select = data;
    else model_layout = data[0];
    @(posedge clk_i);
  endtask

  task automatic run_events(input int unsigned n_items);
    int unsigned          target;
    int unsigned          pick;
    int unsigned          count;
    int unsigned          cut;
    bit                   break_data;
    bit                   broken;
    logic [WordWidth-1:0] w;
    target = sent_count + n_items;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word($urandom);
      end else begin
        count      = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6);
        break_data = (pick >= 85 && pick < 93);
        cut        = $urandom_range(count);
        broken     = 1'b0;
        w          = word_of_type(TypeHeader);
        w[13:8]    = count[5:0];
        send_word(w);
        for (int unsigned i = 0; i < count && !broken; i++) begin
          if (break_data && i == cut) begin
            send_word(word_not_of_type(TypeData));
            broken = 1'b1;
          end else begin
            w = word_of_type(TypeData);
            if ($urandom_range(1) == 1) begin
              if (model_layout) w[20:17] = model_select[3:0];
              else w[20:16] = model_select;
            end
            send_word(w);
          end
        end
        if (!broken) begin
          if (pick >= 93) send_word(word_not_of_type(TypeEob));
          else send_word(word_of_type(TypeEob));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always begin
    @(hold_off_go);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h status %0d",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        head = awaited_reports.pop_front();
        if (m_axis_tdata_o !== {4'h0, head.value}) begin
          $display("%0t: value mismatch, expected %h, actual %h",
                   $time, {4'h0, head.value}, m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tuser_o !== head.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, head.status, m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned phase_tx [4];
    int unsigned phase_rx [4];
    phase_tx = '{0, 77, 0, 38};
    phase_rx = '{0, 0, 77, 38};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == RowCfg) begin
        wait_idle();
        write_reg(directed_rows[r].cfg_index, directed_rows[r].cfg_data);
      end else begin
        send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].t_emit,
                  directed_rows[r].t_value, directed_rows[r].t_status);
      end
    end

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      tx_idle_pct   = phase_tx[p];
      rx_stall_pct <= phase_rx[p];
      write_reg(CfgChannelSelect, (p == 0) ? 5'd31 : (p == 1) ? 5'd0 : 5'($urandom_range(31)));
      write_reg(CfgChannelLayout, 5'(p % 2));
      run_events(PhaseItems);
    end

    // hold the output off while the source keeps offering, then drain
    wait_idle();
    tx_idle_pct   = 0;
    rx_stall_pct <= 0;
    -> hold_off_go;
    run_events(60);
    wait_drained();
    run_events(40);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/qdc_ebp_pkg.sv
hw/rtl/qdc_ebp_in_reg.sv
hw/rtl/qdc_ebp_core.sv
hw/rtl/qdc_ebp_out_reg.sv
hw/rtl/qdc_event_block_parser.sv
dv/tb_top.sv
